// ===== sv/rvx_pkg.sv =====
package rvx_pkg;

  // Major opcodes
  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_IMM    = 7'b0010011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;

  // funct7 codes
  localparam logic [6:0] F7_BASE   = 7'b0000000;
  localparam logic [6:0] F7_ALT    = 7'b0100000;
  localparam logic [6:0] F7_MULDIV = 7'b0000001;

  // funct3 codes
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_DIV  = 3'd4;
  localparam logic [2:0] F3_SRL  = 3'd5;
  localparam logic [2:0] F3_REM  = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_BYTE = 3'd0;
  localparam logic [2:0] F3_DBL  = 3'd3;
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;

  // Result status codes
  localparam logic [1:0] STAT_RUN   = 2'd0;
  localparam logic [1:0] STAT_HALT  = 2'd1;
  localparam logic [1:0] STAT_UNSUP = 2'd2;
  localparam logic [1:0] STAT_MISAL = 2'd3;

  // Command codes
  localparam logic CMD_START = 1'b0;

  // Configuration register indexes
  localparam logic [2:0] CFG_START_PC = 3'd0;
  localparam logic [2:0] CFG_ARG0     = 3'd1;
  localparam logic [2:0] CFG_ARG1     = 3'd2;
  localparam logic [2:0] CFG_ARG2     = 3'd3;
  localparam logic [2:0] CFG_ARG3     = 3'd4;
  localparam logic [2:0] CFG_STACK    = 3'd5;
  localparam logic [2:0] CFG_RET_MARK = 3'd6;
  localparam int         CFG_NUM      = 7;

  localparam logic [63:0] STACK_RESET = 64'd4096;
  localparam logic [63:0] SIGN64      = 64'h8000_0000_0000_0000;

  // Multiply / divide operation
  typedef logic [1:0] md_op_t;
  localparam md_op_t MD_MUL = 2'd0;
  localparam md_op_t MD_DIV = 2'd1;
  localparam md_op_t MD_REM = 2'd2;

  typedef struct packed {
    logic   go;
    md_op_t op;
  } md_req_t;

endpackage

// ===== sv/rvx_in_if.sv =====
interface rvx_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] instr_word;

  modport source (output valid, cmd, instr_word, input ready);
  modport sink   (input valid, cmd, instr_word, output ready);
endinterface

// ===== sv/rvx_out_if.sv =====
interface rvx_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] next_pc;
  logic [63:0] ret_value;
  logic [1:0]  status;

  modport source (output valid, next_pc, ret_value, status, input ready);
  modport sink   (input valid, next_pc, ret_value, status, output ready);
endinterface

// ===== sv/rvx_muldiv.sv =====
module rvx_muldiv
  import rvx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  md_req_t     req,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done,
  output logic [63:0] res
);

  localparam logic [1:0] MS_IDLE = 2'd0;
  localparam logic [1:0] MS_RUN  = 2'd1;
  localparam logic [1:0] MS_FIX  = 2'd2;

  logic [1:0]  mst_r;
  md_op_t      op_r;
  logic [63:0] acc_r;
  logic [63:0] quo_r;
  logic [63:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        neg_q_r;
  logic        neg_rm_r;
  logic        done_r;
  logic [63:0] res_r;

  logic [63:0] rem_sh;
  logic [64:0] diff;

  // One restoring divide step
  assign rem_sh = {acc_r[62:0], quo_r[63]};
  assign diff   = {1'b0, rem_sh} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mst_r  <= MS_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (mst_r)
        MS_IDLE: begin
          if (req.go) begin
            op_r  <= req.op;
            cnt_r <= '0;
            acc_r <= '0;
            if (req.op == MD_MUL) begin
              quo_r <= a_i;
              dvs_r <= b_i;
              mst_r <= MS_RUN;
            end else if (b_i == '0) begin
              // divide by zero
              res_r  <= (req.op == MD_DIV) ? '1 : a_i;
              done_r <= 1'b1;
            end else if (a_i == SIGN64 && b_i == '1) begin
              // signed overflow
              res_r  <= (req.op == MD_DIV) ? a_i : '0;
              done_r <= 1'b1;
            end else begin
              quo_r    <= a_i[63] ? (64'd0 - a_i) : a_i;
              dvs_r    <= b_i[63] ? (64'd0 - b_i) : b_i;
              neg_q_r  <= a_i[63] ^ b_i[63];
              neg_rm_r <= a_i[63];
              mst_r    <= MS_RUN;
            end
          end
        end
        MS_RUN: begin
          if (op_r == MD_MUL) begin
            // shift-add, one multiplier bit a cycle
            if (quo_r[0]) acc_r <= acc_r + dvs_r;
            quo_r <= {1'b0, quo_r[63:1]};
            dvs_r <= {dvs_r[62:0], 1'b0};
          end else if (!diff[64]) begin
            acc_r <= diff[63:0];
            quo_r <= {quo_r[62:0], 1'b1};
          end else begin
            acc_r <= rem_sh;
            quo_r <= {quo_r[62:0], 1'b0};
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) mst_r <= MS_FIX;
        end
        MS_FIX: begin
          // apply signs to a quotient or remainder; a product passes as it is
          if (op_r == MD_MUL) res_r <= acc_r;
          else if (op_r == MD_DIV) res_r <= neg_q_r ? (64'd0 - quo_r) : quo_r;
          else res_r <= neg_rm_r ? (64'd0 - acc_r) : acc_r;
          done_r <= 1'b1;
          mst_r  <= MS_IDLE;
        end
        default: mst_r <= MS_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// ===== sv/rv64_subset_instruction_execute.sv =====
// Channel  | Port group            | Direction | Word
// ---------+-----------------------+-----------+----------------------------------
// input    | in_ch (rvx_in_if)     | sink      | cmd, instr_word
// result   | out_ch (rvx_out_if)   | source    | next_pc, ret_value, status
// config   | psel/penable/paddr... | APB slave | 7 x 64-bit registers at 8*i
//
// One word is in work at a time. LB, LD and SB pass a data memory wait state;
// an execute word while halted goes straight to the finish state; MUL/DIV/REM
// wait on the bit-serial multiply/divide unit (64 steps), which skips its steps
// on a divide by zero or a signed overflow.
// The register file and data memory reads are registered.
// Synchronous active-low reset; register file reads as zero until written.
// A finished result waits in the output register; a new word is taken
// meanwhile, and the block holds in its finish state only if that register
// is still full.
module rv64_subset_instruction_execute
  import rvx_pkg::*;
#(
  parameter int DMEM_WORDS = 512
) (
  input  logic         clk,
  input  logic         rst_n,
  rvx_in_if.sink       in_ch,
  rvx_out_if.source    out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  localparam int DmAw = $clog2(DMEM_WORDS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_LDW   = 3'd3;
  localparam logic [2:0] S_SBW   = 3'd4;
  localparam logic [2:0] S_MDW   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  // Configuration registers
  logic [63:0] cfg_r [CFG_NUM];
  logic [2:0]  cfg_idx;

  assign cfg_idx = paddr[5:3];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CFG_NUM; i++) cfg_r[i] <= '0;
      cfg_r[CFG_STACK] <= STACK_RESET;
    end else if (psel && penable && pwrite && cfg_idx != 3'd7) begin
      cfg_r[cfg_idx] <= pwdata;
    end
  end

  assign prdata = (cfg_idx != 3'd7) ? cfg_r[cfg_idx] : '0;

  // Control state
  logic [2:0]      state_r, state_nxt;
  logic [31:0]     iw_r;
  logic [63:0]     pc_r, pc_nxt;
  logic [63:0]     a0_r;
  logic [1:0]      code_r, code_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  logic [2:0]      lane_r, lane_nxt;
  logic [DmAw-1:0] didx_r, didx_nxt;
  logic            in_acc;

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  // Register file
  logic [63:0] rf_mem [32];
  logic [31:0] rf_vld_r;
  logic [63:0] rs1_q, rs2_q;
  logic        rs1_v_r, rs2_v_r;
  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [63:0] rf_wd;

  always_ff @(posedge clk) begin
    if (rf_we) rf_mem[rf_wa] <= rf_wd;
    if (in_acc) begin
      rs1_q <= rf_mem[in_ch.instr_word[19:15]];
      rs2_q <= rf_mem[in_ch.instr_word[24:20]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
      a0_r     <= '0;
    end else begin
      if (rf_we) begin
        rf_vld_r[rf_wa] <= 1'b1;
        if (rf_wa == 5'd10) a0_r <= rf_wd;
      end
      if (in_acc) begin
        rs1_v_r <= rf_vld_r[in_ch.instr_word[19:15]];
        rs2_v_r <= rf_vld_r[in_ch.instr_word[24:20]];
      end
    end
  end

  // Data memory
  logic [63:0]     dm_mem [DMEM_WORDS];
  logic [63:0]     dm_q;
  logic            dm_re, dm_we;
  logic [DmAw-1:0] dm_ra, dm_wa;
  logic [63:0]     dm_wd;

  always_ff @(posedge clk) begin
    if (dm_we) dm_mem[dm_wa] <= dm_wd;
    if (dm_re) dm_q <= dm_mem[dm_ra];
  end

  // Decode fields and operands
  logic [6:0]  opc, f7;
  logic [2:0]  f3;
  logic [4:0]  rd;
  logic        rd_nz;
  logic [63:0] opa, opb, immi, imms, immb, immj, pc4, ld_addr, st_addr;
  logic [7:0]  ld_byte;

  assign opc     = iw_r[6:0];
  assign rd      = iw_r[11:7];
  assign f3      = iw_r[14:12];
  assign f7      = iw_r[31:25];
  assign rd_nz   = (rd != 5'd0);
  assign opa     = rs1_v_r ? rs1_q : '0;
  assign opb     = rs2_v_r ? rs2_q : '0;
  assign immi    = {{52{iw_r[31]}}, iw_r[31:20]};
  assign imms    = {{52{iw_r[31]}}, iw_r[31:25], iw_r[11:7]};
  assign immb    = {{51{iw_r[31]}}, iw_r[31], iw_r[7], iw_r[30:25], iw_r[11:8], 1'b0};
  assign immj    = {{43{iw_r[31]}}, iw_r[31], iw_r[19:12], iw_r[20], iw_r[30:21], 1'b0};
  assign pc4     = pc_r + 64'd4;
  assign ld_addr = opa + immi;
  assign st_addr = opa + imms;
  assign ld_byte = dm_q[{lane_r, 3'b000} +: 8];

  // Multiply / divide unit
  md_req_t     md_req;
  logic        md_done;
  logic [63:0] md_res;

  rvx_muldiv u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .a_i   (opa),
    .b_i   (opb),
    .done  (md_done),
    .res   (md_res)
  );

  // Output register
  logic        out_valid_r;
  logic [63:0] out_pc_r, out_a0_r;
  logic [1:0]  out_st_r;
  logic        out_load;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    code_nxt  = code_r;
    cnt_nxt   = cnt_r;
    lane_nxt  = lane_r;
    didx_nxt  = didx_r;
    rf_we     = 1'b0;
    rf_wa     = rd;
    rf_wd     = '0;
    dm_re     = 1'b0;
    dm_we     = 1'b0;
    dm_ra     = ld_addr[3 +: DmAw];
    dm_wa     = st_addr[3 +: DmAw];
    dm_wd     = opb;
    md_req    = '0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          code_nxt = STAT_RUN;
          if (in_ch.cmd == CMD_START) begin
            pc_nxt    = cfg_r[CFG_START_PC];
            cnt_nxt   = 3'd0;
            state_nxt = S_START;
          end else if (pc_r == cfg_r[CFG_RET_MARK]) begin
            code_nxt  = STAT_HALT;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_START: begin
        // load ra, sp, a0..a3 one per cycle
        rf_we = 1'b1;
        case (cnt_r)
          3'd0: begin rf_wa = 5'd1;  rf_wd = cfg_r[CFG_RET_MARK]; end
          3'd1: begin rf_wa = 5'd2;  rf_wd = cfg_r[CFG_STACK];    end
          3'd2: begin rf_wa = 5'd10; rf_wd = cfg_r[CFG_ARG0];     end
          3'd3: begin rf_wa = 5'd11; rf_wd = cfg_r[CFG_ARG1];     end
          3'd4: begin rf_wa = 5'd12; rf_wd = cfg_r[CFG_ARG2];     end
          3'd5: begin rf_wa = 5'd13; rf_wd = cfg_r[CFG_ARG3];     end
          default: rf_we = 1'b0;
        endcase
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd5) state_nxt = S_FIN;
      end
      S_EXEC: begin
        state_nxt = S_FIN;
        case (opc)
          OPC_OP: begin
            pc_nxt = pc4;
            rf_we  = rd_nz;
            if (f3 == F3_ADD && f7 == F7_BASE) rf_wd = opa + opb;
            else if (f3 == F3_ADD && f7 == F7_ALT) rf_wd = opa - opb;
            else if (f3 == F3_SLL && f7 == F7_BASE) rf_wd = opa << opb[5:0];
            else if (f3 == F3_SRL && f7 == F7_BASE) rf_wd = opa >> opb[5:0];
            else if (f3 == F3_AND && f7 == F7_BASE) rf_wd = opa & opb;
            else if (f7 == F7_MULDIV &&
                     (f3 == F3_ADD || f3 == F3_DIV || f3 == F3_REM)) begin
              rf_we     = 1'b0;
              md_req.go = 1'b1;
              md_req.op = (f3 == F3_ADD) ? MD_MUL : ((f3 == F3_DIV) ? MD_DIV : MD_REM);
              state_nxt = S_MDW;
            end else begin
              rf_we    = 1'b0;
              pc_nxt   = pc_r;
              code_nxt = STAT_UNSUP;
            end
          end
          OPC_IMM: begin
            if (f3 == F3_ADD) begin
              rf_we  = rd_nz;
              rf_wd  = ld_addr;
              pc_nxt = pc4;
            end else if (f3 == F3_SRL && iw_r[31:26] == 6'd0) begin
              rf_we  = rd_nz;
              rf_wd  = opa >> iw_r[25:20];
              pc_nxt = pc4;
            end else begin
              code_nxt = STAT_UNSUP;
            end
          end
          OPC_LOAD: begin
            if (f3 == F3_BYTE || (f3 == F3_DBL && ld_addr[2:0] == 3'd0)) begin
              dm_re     = 1'b1;
              lane_nxt  = ld_addr[2:0];
              pc_nxt    = pc4;
              state_nxt = S_LDW;
            end else if (f3 == F3_DBL) begin
              code_nxt = STAT_MISAL;
            end else begin
              code_nxt = STAT_UNSUP;
            end
          end
          OPC_STORE: begin
            if (f3 == F3_BYTE) begin
              // read the word, merge the byte next cycle
              dm_re     = 1'b1;
              dm_ra     = st_addr[3 +: DmAw];
              lane_nxt  = st_addr[2:0];
              didx_nxt  = st_addr[3 +: DmAw];
              pc_nxt    = pc4;
              state_nxt = S_SBW;
            end else if (f3 == F3_DBL && st_addr[2:0] == 3'd0) begin
              dm_we  = 1'b1;
              pc_nxt = pc4;
            end else if (f3 == F3_DBL) begin
              code_nxt = STAT_MISAL;
            end else begin
              code_nxt = STAT_UNSUP;
            end
          end
          OPC_JAL: begin
            rf_we  = rd_nz;
            rf_wd  = pc4;
            pc_nxt = pc_r + immj;
          end
          OPC_JALR: begin
            if (f3 == F3_ADD) begin
              rf_we  = rd_nz;
              rf_wd  = pc4;
              pc_nxt = {ld_addr[63:1], 1'b0};
            end else begin
              code_nxt = STAT_UNSUP;
            end
          end
          OPC_BRANCH: begin
            if (f3 == F3_BEQ) pc_nxt = (opa == opb) ? pc_r + immb : pc4;
            else if (f3 == F3_BNE) pc_nxt = (opa != opb) ? pc_r + immb : pc4;
            else if (f3 == F3_BLT) pc_nxt = ($signed(opa) < $signed(opb)) ? pc_r + immb : pc4;
            else code_nxt = STAT_UNSUP;
          end
          default: code_nxt = STAT_UNSUP;
        endcase
      end
      S_LDW: begin
        rf_we     = rd_nz;
        rf_wd     = (f3 == F3_BYTE) ? {{56{ld_byte[7]}}, ld_byte} : dm_q;
        state_nxt = S_FIN;
      end
      S_SBW: begin
        dm_we = 1'b1;
        dm_wa = didx_r;
        dm_wd = dm_q;
        dm_wd[{lane_r, 3'b000} +: 8] = opb[7:0];
        state_nxt = S_FIN;
      end
      S_MDW: begin
        if (md_done) begin
          rf_we     = rd_nz;
          rf_wd     = md_res;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
      code_r  <= STAT_RUN;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      code_r  <= code_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
    didx_r <= didx_nxt;
    if (in_acc) iw_r <= in_ch.instr_word;
  end

  // Result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pc_r <= pc_r;
      out_a0_r <= a0_r;
      out_st_r <= (code_r == STAT_RUN && pc_r == cfg_r[CFG_RET_MARK]) ? STAT_HALT : code_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.next_pc   = out_pc_r;
  assign out_ch.ret_value = out_a0_r;
  assign out_ch.status    = out_st_r;

endmodule

// ===== sv/rvx_chk.sv =====
module rvx_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result word dropped or changed while stalled");

  // one word in work at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a word is in work");

  // reset empties the output register
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rv64_subset_instruction_execute rvx_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status)
);
